// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the segment box RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define SBNH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same check on the default block clock and reset names.
`define SBNH_ASSERT_CLK(label, prop, msg) \
    `SBNH_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/sbnh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbnh_pkg
// Shared constants and types of the segment box nearest hit block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbnh_pkg;

    localparam int ENTRY_COUNT  = 64;
    localparam int IDX_W        = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CMP_W        = 13;

    localparam int COORD_W      = 32;
    localparam int DIR_W        = 33;
    localparam int NUM_W        = 34;
    localparam int FRAC_W       = 17;
    localparam int T_W          = 18;

    localparam int FRACTION_ONE = 65536;
    localparam int T_SAT        = 65537;

    localparam int STEP_CNT     = 17;
    localparam int CNT_W        = $clog2(STEP_CNT + 1);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic                      solid;
        logic signed [COORD_W-1:0] half_z;
        logic signed [COORD_W-1:0] half_y;
        logic signed [COORD_W-1:0] half_x;
        logic signed [COORD_W-1:0] center_z;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_x;
    } t_box;

    typedef struct packed {
        logic                  done;
        logic signed [T_W-1:0] t;
    } t_div_res;

endpackage

`default_nettype wire

// ===== rtl/segment_box_nearest_hit.sv =====
// ----------------------------------------------------------------------------
// segment_box_nearest_hit
// Box table with nearest segment hit query (slab method, Q16.16 / Q1.16).
// ----------------------------------------------------------------------------
// Writes and clears keep busy low. A query holds busy high as it walks the
// table one entry at a time: an invalid or skipped entry is done in the
// issue state, a non-solid entry in the bounds state, and a usable entry
// waits on the six serial dividers (17 restoring steps plus setup).
// One result appears on o_valid for a single cycle when the walk ends, in
// the cycle busy falls; it must be taken then, as it is not held.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module segment_box_nearest_hit
    import sbnh_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                i_operation,
    input  wire logic [5:0]                i_entry_index,
    input  wire logic signed [COORD_W-1:0] i_first_x,
    input  wire logic signed [COORD_W-1:0] i_first_y,
    input  wire logic signed [COORD_W-1:0] i_first_z,
    input  wire logic signed [COORD_W-1:0] i_second_x,
    input  wire logic signed [COORD_W-1:0] i_second_y,
    input  wire logic signed [COORD_W-1:0] i_second_z,
    input  wire logic                      i_solid_mark,
    input  wire logic [5:0]                i_skip_index,
    input  wire logic                      i_skip_enable,
    output logic                           o_valid,
    output logic [FRAC_W-1:0]              o_hit_fraction
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ISSUE, ST_BOUNDS, ST_NUMER, ST_DIVGO, ST_DIVWAIT, ST_REDUCE,
        ST_UPDATE
    } t_state;

    t_state                    r_state;
    logic [ENTRY_COUNT-1:0]    r_valid;
    logic [IDX_W-1:0]          r_scan;
    logic [5:0]                r_skip;
    logic                      r_skip_en;
    logic [FRAC_W-1:0]         r_best;
    logic                      r_out_valid;
    logic [FRAC_W-1:0]         r_out;
    logic signed [COORD_W-1:0] r_p [3];
    logic signed [DIR_W-1:0]   r_d [3];
    logic signed [DIR_W-1:0]   r_lo [3];
    logic signed [DIR_W-1:0]   r_hi [3];
    logic signed [NUM_W-1:0]   r_num_lo [3];
    logic signed [NUM_W-1:0]   r_num_hi [3];
    logic [2:0]                r_dzero;
    logic [2:0]                r_zfail;
    logic [FRAC_W-1:0]         r_tmin;
    logic                      r_miss;

    logic                      accept;
    logic [CMP_W-1:0]          wide_idx;
    logic                      in_range;
    t_box                      wr_box;
    t_box                      rd_box;
    logic [$bits(t_box)-1:0]   ram_rdata;
    logic                      usable;
    logic                      last;
    logic                      ram_re;
    logic signed [COORD_W-1:0] c [3];
    logic signed [COORD_W-1:0] h [3];
    t_div_res                  div_lo [3];
    t_div_res                  div_hi [3];
    logic signed [T_W-1:0]     tmin;
    logic signed [T_W-1:0]     tmax;
    logic                      fail;
    logic [FRAC_W-1:0]         next_best;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign wide_idx = CMP_W'(i_entry_index);
    assign in_range = wide_idx < CMP_W'(ENTRY_COUNT);

    always_comb begin
        wr_box.solid    = i_solid_mark;
        wr_box.center_x = i_first_x;
        wr_box.center_y = i_first_y;
        wr_box.center_z = i_first_z;
        wr_box.half_x   = i_second_x;
        wr_box.half_y   = i_second_y;
        wr_box.half_z   = i_second_z;
    end

    assign usable = r_valid[r_scan]
                    && !(r_skip_en && CMP_W'(r_skip) == CMP_W'(r_scan));
    assign last   = r_scan == IDX_W'(ENTRY_COUNT - 1);
    assign ram_re = (r_state == ST_ISSUE) && usable;

    sbnh_ram #(
        .WIDTH ($bits(t_box)),
        .DEPTH (ENTRY_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && i_operation == OP_WRITE && in_range),
        .i_waddr (wide_idx[IDX_W-1:0]),
        .i_wdata (wr_box),
        .i_re    (ram_re),
        .i_raddr (r_scan),
        .o_rdata (ram_rdata)
    );

    assign rd_box = t_box'(ram_rdata);

    always_comb begin
        c[0] = rd_box.center_x;
        c[1] = rd_box.center_y;
        c[2] = rd_box.center_z;
        h[0] = rd_box.half_x;
        h[1] = rd_box.half_y;
        h[2] = rd_box.half_z;
    end

    for (genvar g = 0; g < 3; g++) begin : g_axis
        sbnh_div u_div_lo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_state == ST_DIVGO),
            .i_num   (r_num_lo[g]),
            .i_den   (r_d[g]),
            .o_res   (div_lo[g])
        );
        sbnh_div u_div_hi (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_state == ST_DIVGO),
            .i_num   (r_num_hi[g]),
            .i_den   (r_d[g]),
            .o_res   (div_hi[g])
        );
    end

    always_comb begin
        logic signed [T_W-1:0] t1;
        logic signed [T_W-1:0] t2;
        tmin = '0;
        tmax = T_W'(FRACTION_ONE);
        fail = 1'b0;
        for (int a = 0; a < 3; a++) begin
            t1 = div_lo[a].t;
            t2 = div_hi[a].t;
            if (t1 > t2) begin
                t1 = div_hi[a].t;
                t2 = div_lo[a].t;
            end
            if (r_dzero[a]) begin
                fail = fail | r_zfail[a];
            end else begin
                if (t1 > tmin) begin
                    tmin = t1;
                end
                if (t2 < tmax) begin
                    tmax = t2;
                end
            end
        end
    end

    assign next_best = (!r_miss && r_tmin < r_best) ? r_tmin : r_best;

    // Valid marks per entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (accept && in_range) begin
            if (i_operation == OP_WRITE) begin
                r_valid[wide_idx[IDX_W-1:0]] <= 1'b1;
            end else if (i_operation == OP_CLEAR) begin
                r_valid[wide_idx[IDX_W-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_operation == OP_QUERY) begin
                        r_p[0]    <= i_first_x;
                        r_p[1]    <= i_first_y;
                        r_p[2]    <= i_first_z;
                        r_d[0]    <= DIR_W'(i_second_x) - DIR_W'(i_first_x);
                        r_d[1]    <= DIR_W'(i_second_y) - DIR_W'(i_first_y);
                        r_d[2]    <= DIR_W'(i_second_z) - DIR_W'(i_first_z);
                        r_skip    <= i_skip_index;
                        r_skip_en <= i_skip_enable;
                        r_best    <= FRAC_W'(FRACTION_ONE);
                        r_scan    <= '0;
                        r_state   <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (usable) begin
                        r_state <= ST_BOUNDS;
                    end else if (last) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_best;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                ST_BOUNDS: begin
                    for (int a = 0; a < 3; a++) begin
                        r_lo[a] <= DIR_W'(c[a]) - DIR_W'(h[a]);
                        r_hi[a] <= DIR_W'(c[a]) + DIR_W'(h[a]);
                    end
                    if (rd_box.solid) begin
                        r_state <= ST_NUMER;
                    end else if (last) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_best;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_NUMER: begin
                    for (int a = 0; a < 3; a++) begin
                        r_num_lo[a] <= NUM_W'(r_lo[a]) - NUM_W'(r_p[a]);
                        r_num_hi[a] <= NUM_W'(r_hi[a]) - NUM_W'(r_p[a]);
                        r_dzero[a]  <= (r_d[a] == '0);
                        r_zfail[a]  <= (r_p[a] < r_lo[a]) || (r_p[a] > r_hi[a]);
                    end
                    r_state <= ST_DIVGO;
                end
                ST_DIVGO: begin
                    r_state <= ST_DIVWAIT;
                end
                ST_DIVWAIT: begin
                    if (div_lo[0].done) begin
                        r_state <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    r_tmin  <= tmin[FRAC_W-1:0];
                    r_miss  <= fail || (tmin > tmax);
                    r_state <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    r_best <= next_best;
                    if (last) begin
                        r_out_valid <= 1'b1;
                        r_out       <= next_best;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit_fraction = r_out;

    `SBNH_ASSERT_CLK(a_one_strobe, o_valid |=> !o_valid,
        "result strobe longer than one cycle")
    `SBNH_ASSERT_CLK(a_frac_range, o_valid |-> (o_hit_fraction <= FRAC_W'(FRACTION_ONE)),
        "hit fraction above one")
    `SBNH_ASSERT_CLK(a_query_busy, (accept && i_operation == OP_QUERY) |=> busy,
        "query accepted without going busy")
    `SBNH_ASSERT_CLK(a_write_quiet, (accept && i_operation != OP_QUERY) |=> (!busy && !o_valid),
        "write or clear produced activity")

endmodule

`default_nettype wire

// ===== rtl/sbnh_ram.sv =====
// ----------------------------------------------------------------------------
// sbnh_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbnh_div.sv =====
// ----------------------------------------------------------------------------
// sbnh_div
// Slab fraction divider: floor(num * 65536 / den), clamped to [-1, 65537],
// one restoring step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sbnh_div
    import sbnh_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic signed [DIR_W-1:0] i_den,
    output t_div_res                     o_res
);

    typedef enum logic [1:0] {K_NEG, K_ZERO, K_SAT, K_NORM} t_kind;

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [NUM_W:0]     r_a;
    logic [DIR_W-1:0]          r_b;
    t_kind                     r_kind;
    logic [NUM_W-1:0]          r_rem;
    logic [FRAC_W-1:0]         r_q;

    logic [NUM_W:0]            diff;
    logic                      q_bit;
    logic [NUM_W-1:0]          rem_keep;

    assign diff     = {1'b0, r_rem} - {2'b00, r_b};
    assign q_bit    = !diff[NUM_W];
    assign rem_keep = q_bit ? diff[NUM_W-1:0] : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_den[DIR_W-1] ? -(NUM_W+1)'(i_num) : (NUM_W+1)'(i_num);
                r_b    <= i_den[DIR_W-1] ? DIR_W'(-i_den) : DIR_W'(i_den);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    priority if (r_a < 0) begin
                        r_kind <= K_NEG;
                    end else if (r_a == 0) begin
                        r_kind <= K_ZERO;
                    end else if (r_a >= $signed({1'b0, r_b, 1'b0})) begin
                        r_kind <= K_SAT;
                    end else begin
                        r_kind <= K_NORM;
                    end
                    r_rem <= r_a[NUM_W-1:0];
                    r_q   <= '0;
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_q   <= {r_q[FRAC_W-2:0], q_bit};
                    r_rem <= {rem_keep[NUM_W-2:0], 1'b0};
                    if (r_cnt == CNT_W'(STEP_CNT)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_res.done = r_done;
        unique case (r_kind)
            K_NEG:   o_res.t = -T_W'(1);
            K_ZERO:  o_res.t = '0;
            K_SAT:   o_res.t = T_W'(T_SAT);
            K_NORM:  o_res.t = (T_W'(r_q) > T_W'(T_SAT)) ? T_W'(T_SAT) : T_W'(r_q);
            default: o_res.t = '0;
        endcase
    end

    `SBNH_ASSERT_CLK(a_div_range,
        o_res.done |-> (o_res.t >= -T_W'(1) && o_res.t <= T_W'(T_SAT)),
        "divider result out of clamp range")
    `SBNH_ASSERT_CLK(a_div_done_late, i_start |=> !r_done,
        "divider done right after start")

endmodule

`default_nettype wire

// ===== dv/segment_box_nearest_hit_tb.sv =====
// ----------------------------------------------------------------------------
// segment_box_nearest_hit_tb
// Self-checking bench for the box table and its nearest segment hit query.
// Writes, clears and queries are issued in bursts with random gaps. A
// scoreboard keeps its own copy of the box table, runs the slab clip on
// every accepted query and compares each hit fraction in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_box_nearest_hit_tb;
    import sbnh_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int          Q_ONE     = 65536;
    localparam int          WD_LIMIT  = 20000;
    localparam int          N_RANDOM  = 1330;

    typedef struct {
        logic [1:0]                op;
        logic [5:0]                idx;
        logic signed [COORD_W-1:0] fx, fy, fz, sx, sy, sz;
        logic                      solid;
        logic [5:0]                skip;
        logic                      skip_en;
    } t_word;

    class hit_scoreboard;
        bit                       valid_q[ENTRY_COUNT];
        bit                       solid_q[ENTRY_COUNT];
        longint                   ctr[ENTRY_COUNT][3];
        longint                   half[ENTRY_COUNT][3];
        logic [FRAC_W-1:0]        pending[$];
        int                       errors;
        int                       n_query;
        int                       n_hit;

        function longint floor_frac(longint num, longint den);
            longint a;
            longint q;
            a = num * 65536;
            if (den < 0) begin
                a = -a;
                den = -den;
            end
            q = a / den;
            if ((a % den) != 0 && a < 0) q = q - 1;
            return q;
        endfunction

        function longint clip_box(longint p[3], longint d[3], int e);
            longint tmin;
            longint tmax;
            longint lo, hi, t1, t2, s;
            tmin = 0;
            tmax = Q_ONE;
            for (int ax = 0; ax < 3; ax++) begin
                lo = ctr[e][ax] - half[e][ax];
                hi = ctr[e][ax] + half[e][ax];
                if (d[ax] == 0) begin
                    if (p[ax] < lo || p[ax] > hi) return Q_ONE;
                end else begin
                    t1 = floor_frac(lo - p[ax], d[ax]);
                    t2 = floor_frac(hi - p[ax], d[ax]);
                    if (t1 > t2) begin
                        s = t1;
                        t1 = t2;
                        t2 = s;
                    end
                    if (t1 > tmin) tmin = t1;
                    if (t2 < tmax) tmax = t2;
                    if (tmin > tmax) return Q_ONE;
                end
            end
            return tmin;
        endfunction

        function void note_word(t_word w);
            longint p[3];
            longint d[3];
            longint best;
            longint t;
            case (w.op)
                OP_WRITE: begin
                    valid_q[w.idx] = 1;
                    solid_q[w.idx] = w.solid;
                    ctr[w.idx][0] = w.fx;
                    ctr[w.idx][1] = w.fy;
                    ctr[w.idx][2] = w.fz;
                    half[w.idx][0] = w.sx;
                    half[w.idx][1] = w.sy;
                    half[w.idx][2] = w.sz;
                end
                OP_CLEAR: valid_q[w.idx] = 0;
                OP_QUERY: begin
                    p[0] = w.fx;
                    p[1] = w.fy;
                    p[2] = w.fz;
                    d[0] = longint'(w.sx) - p[0];
                    d[1] = longint'(w.sy) - p[1];
                    d[2] = longint'(w.sz) - p[2];
                    best = Q_ONE;
                    for (int e = 0; e < ENTRY_COUNT; e++) begin
                        if (!valid_q[e] || !solid_q[e]) continue;
                        if (w.skip_en && e == w.skip) continue;
                        t = clip_box(p, d, e);
                        if (t < best) best = t;
                    end
                    n_query++;
                    if (best != Q_ONE) n_hit++;
                    pending.push_back(best[FRAC_W-1:0]);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [FRAC_W-1:0] got);
            logic [FRAC_W-1:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected hit_fraction %0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: hit_fraction expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                i_operation;
    logic [5:0]                i_entry_index;
    logic signed [COORD_W-1:0] i_first_x, i_first_y, i_first_z;
    logic signed [COORD_W-1:0] i_second_x, i_second_y, i_second_z;
    logic                      i_solid_mark;
    logic [5:0]                i_skip_index;
    logic                      i_skip_enable;
    logic                      o_valid;
    logic [FRAC_W-1:0]         o_hit_fraction;

    hit_scoreboard sb;
    int            idle_cycles;

    segment_box_nearest_hit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_first_x      (i_first_x),
        .i_first_y      (i_first_y),
        .i_first_z      (i_first_z),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .i_second_z     (i_second_z),
        .i_solid_mark   (i_solid_mark),
        .i_skip_index   (i_skip_index),
        .i_skip_enable  (i_skip_enable),
        .o_valid        (o_valid),
        .o_hit_fraction (o_hit_fraction)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_hit_fraction);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(t_word w);
        start         <= 1;
        i_operation   <= w.op;
        i_entry_index <= w.idx;
        i_first_x     <= w.fx;
        i_first_y     <= w.fy;
        i_first_z     <= w.fz;
        i_second_x    <= w.sx;
        i_second_y    <= w.sy;
        i_second_z    <= w.sz;
        i_solid_mark  <= w.solid;
        i_skip_index  <= w.skip;
        i_skip_enable <= w.skip_en;
        do @(posedge i_clk); while (busy);
        sb.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic hold_off(int n);
        start <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic t_word make_word(logic [1:0] op, int idx,
                                        int fx, int fy, int fz,
                                        int sx, int sy, int sz,
                                        bit solid, int skip, bit skip_en);
        t_word w;
        w.op = op; w.idx = idx[5:0];
        w.fx = fx; w.fy = fy; w.fz = fz;
        w.sx = sx; w.sy = sy; w.sz = sz;
        w.solid = solid; w.skip = skip[5:0]; w.skip_en = skip_en;
        return w;
    endfunction

    function automatic int near_coord(int span);
        return $urandom_range(0, 2 * span * Q_ONE) - span * Q_ONE;
    endfunction

    function automatic t_word random_word();
        t_word w;
        int    r;
        r = $urandom_range(0, 99);
        w = make_word(OP_WRITE, $urandom_range(0, 63),
                      near_coord(20), near_coord(20), near_coord(20),
                      $urandom_range(0, 6 * Q_ONE), $urandom_range(0, 6 * Q_ONE),
                      $urandom_range(0, 6 * Q_ONE), $urandom_range(0, 9) != 0,
                      $urandom_range(0, 63), $urandom_range(0, 1));
        if (r < 30) begin
            if ($urandom_range(0, 9) == 0) begin
                w.fx = $urandom; w.fy = $urandom; w.fz = $urandom;
                w.sx = $urandom; w.sy = $urandom; w.sz = $urandom;
            end else if ($urandom_range(0, 9) == 0) begin
                w.sx = -w.sx;
            end
        end else if (r < 50) begin
            w.op = OP_CLEAR;
        end else if (r < 98) begin
            w.op = OP_QUERY;
            w.fx = near_coord(40); w.fy = near_coord(40); w.fz = near_coord(40);
            w.sx = near_coord(40); w.sy = near_coord(40); w.sz = near_coord(40);
            case ($urandom_range(0, 7))
                0: w.sy = w.fy;
                1: begin w.sx = w.fx; w.sz = w.fz; end
                2: begin
                    w.fx = $urandom; w.fy = $urandom; w.fz = $urandom;
                    w.sx = $urandom; w.sy = $urandom; w.sz = $urandom;
                end
                default: ;
            endcase
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    initial begin
        t_word w;
        int    left;
        int    burst;
        bit    drained;
        sb = new();
        idle_cycles   = 0;
        drained       = 0;
        i_rst_n       = 0;
        start         = 0;
        i_operation   = OP_WRITE;
        i_entry_index = 0;
        i_first_x = 0; i_first_y = 0; i_first_z = 0;
        i_second_x = 0; i_second_y = 0; i_second_z = 0;
        i_solid_mark = 0; i_skip_index = 0; i_skip_enable = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // empty table, extremes, inside start, parallel axes, skip, non-solid
        send_word(make_word(OP_QUERY, 0, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0));
        send_word(make_word(OP_WRITE, 0, 5 * Q_ONE, 0, 0, Q_ONE, Q_ONE, Q_ONE, 1, 0, 0));
        send_word(make_word(OP_QUERY, 0, 0, 0, 0, 10 * Q_ONE, 0, 0, 0, 0, 0));
        send_word(make_word(OP_QUERY, 0, 5 * Q_ONE, 0, 0, 10 * Q_ONE, 0, 0, 0, 0, 0));
        send_word(make_word(OP_QUERY, 0, 0, 2 * Q_ONE, 0, 10 * Q_ONE, 2 * Q_ONE, 0,
                            0, 0, 0));
        send_word(make_word(OP_QUERY, 0, 0, 0, 0, 10 * Q_ONE, 0, 0, 0, 0, 1));
        send_word(make_word(OP_QUERY, 0, 0, 0, 0, 10 * Q_ONE, 0, 0, 0, 5, 1));
        send_word(make_word(OP_WRITE, 63, 3 * Q_ONE, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0));
        send_word(make_word(OP_QUERY, 0, 0, 0, 0, 10 * Q_ONE, 0, 0, 0, 63, 1));
        send_word(make_word(OP_WRITE, 7, 8 * Q_ONE, 0, 0, -Q_ONE, Q_ONE, Q_ONE, 1, 0, 0));
        send_word(make_word(OP_QUERY, 0, 0, 0, 0, 10 * Q_ONE, 0, 0, 0, 0, 1));
        send_word(make_word(OP_QUERY, 0, 8 * Q_ONE, 0, 0, 8 * Q_ONE, 5 * Q_ONE, 0,
                            0, 0, 1));
        send_word(make_word(OP_WRITE, 9, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                            32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1, 0, 0));
        send_word(make_word(OP_QUERY, 63, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                            32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 63, 0));
        send_word(make_word(OP_QUERY, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                            32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 0, 0));
        send_word(make_word(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_CLEAR, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_QUERY, 0, 0, 0, 0, 10 * Q_ONE, 0, 0, 0, 0, 0));
        send_word(make_word(OP_CLEAR, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_QUERY, 0, 0, 0, 0, 10 * Q_ONE, 0, 0, 0, 0, 0));

        left = N_RANDOM;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0) begin
                send_word(random_word());
                burst--;
                left--;
            end
            if (!drained && left <= N_RANDOM / 2) begin
                drained = 1;
                start <= 0;
                @(negedge i_clk);
                while (sb.pending.size() != 0) @(negedge i_clk);
            end else if ($urandom_range(0, 2) != 0) begin
                hold_off($urandom_range(1, 40));
            end
        end
        start <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d queries (%0d with a hit) among writes, clears and unused ops.",
                 sb.n_query, sb.n_hit);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbnh_pkg.sv
rtl/sbnh_ram.sv
rtl/sbnh_div.sv
rtl/segment_box_nearest_hit.sv
dv/segment_box_nearest_hit_tb.sv
